// ===== rtl/lpi_pkg.sv =====
package lpi_pkg;

  // Coordinate and normal port widths
  localparam int COORD_W  = 32;
  localparam int DIR_W    = 33;
  localparam int NORM_W   = 16;
  localparam int THR_W    = 16;
  // den = -(n . dir) stays below 3 * 2^47 in magnitude
  localparam int DEN_W    = 50;
  localparam int QUO_W    = 32;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NORMAL_X  = 3'd0,
    REG_NORMAL_Y  = 3'd1,
    REG_NORMAL_Z  = 3'd2,
    REG_OFFSET    = 3'd3,
    REG_THRESHOLD = 3'd4
  } cfg_reg_e;

  // Per-item data that rides alongside the divider
  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] az;
    logic signed [DIR_W-1:0]   dx;
    logic signed [DIR_W-1:0]   dy;
    logic signed [DIR_W-1:0]   dz;
    logic                      miss;
    logic                      neg;
  } side_t;

endpackage

// ===== rtl/lpi_front.sv =====
module lpi_front import lpi_pkg::*; #(
  parameter int NORMAL_FRAC_BITS = 14,
  parameter int NUM_W            = 51
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic signed [COORD_W-1:0]  ax_i,
  input  logic signed [COORD_W-1:0]  ay_i,
  input  logic signed [COORD_W-1:0]  az_i,
  input  logic signed [COORD_W-1:0]  bx_i,
  input  logic signed [COORD_W-1:0]  by_i,
  input  logic signed [COORD_W-1:0]  bz_i,
  input  logic                       any_dir_i,
  input  logic                       unbounded_i,
  input  logic signed [NORM_W-1:0]   nx_i,
  input  logic signed [NORM_W-1:0]   ny_i,
  input  logic signed [NORM_W-1:0]   nz_i,
  input  logic signed [COORD_W-1:0]  offset_i,
  input  logic [THR_W-1:0]           thr_i,
  output logic                       valid_o,
  output logic [NUM_W-1:0]           an_o,
  output logic [DEN_W-1:0]           ad_o,
  output side_t                      side_o
);

  localparam int PD_W  = NORM_W + DIR_W;       // n * dir
  localparam int PA_W  = NORM_W + COORD_W;     // n * A
  localparam int SQ_W  = 2 * NORM_W;
  localparam int NN_W  = 32;
  localparam int NA_W  = PA_W + 2;
  localparam int DNN_W = COORD_W + NN_W + 1;

  // ---- stage 1: direction, squares, config snapshot
  logic                      v1_q;
  logic signed [COORD_W-1:0] ax1_q, ay1_q, az1_q, d1_q;
  logic signed [DIR_W-1:0]   dx1_q, dy1_q, dz1_q;
  logic signed [NORM_W-1:0]  nx1_q, ny1_q, nz1_q;
  logic [THR_W-1:0]          thr1_q;
  logic                      any1_q, unb1_q;
  logic signed [SQ_W-1:0]    sx1_q, sy1_q, sz1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ax1_q  <= ax_i;
    ay1_q  <= ay_i;
    az1_q  <= az_i;
    dx1_q  <= DIR_W'(bx_i) - DIR_W'(ax_i);
    dy1_q  <= DIR_W'(by_i) - DIR_W'(ay_i);
    dz1_q  <= DIR_W'(bz_i) - DIR_W'(az_i);
    nx1_q  <= nx_i;
    ny1_q  <= ny_i;
    nz1_q  <= nz_i;
    d1_q   <= offset_i;
    thr1_q <= thr_i;
    any1_q <= any_dir_i;
    unb1_q <= unbounded_i;
    sx1_q  <= SQ_W'(nx_i) * SQ_W'(nx_i);
    sy1_q  <= SQ_W'(ny_i) * SQ_W'(ny_i);
    sz1_q  <= SQ_W'(nz_i) * SQ_W'(nz_i);
  end

  // ---- stage 2: dot-product terms
  logic                      v2_q;
  logic signed [COORD_W-1:0] ax2_q, ay2_q, az2_q, d2_q;
  logic signed [DIR_W-1:0]   dx2_q, dy2_q, dz2_q;
  logic [THR_W-1:0]          thr2_q;
  logic                      any2_q, unb2_q;
  logic signed [PD_W-1:0]    pdx2_q, pdy2_q, pdz2_q;
  logic signed [PA_W-1:0]    pax2_q, pay2_q, paz2_q;
  logic [NN_W-1:0]           nn2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ax2_q  <= ax1_q;
    ay2_q  <= ay1_q;
    az2_q  <= az1_q;
    dx2_q  <= dx1_q;
    dy2_q  <= dy1_q;
    dz2_q  <= dz1_q;
    d2_q   <= d1_q;
    thr2_q <= thr1_q;
    any2_q <= any1_q;
    unb2_q <= unb1_q;
    pdx2_q <= PD_W'(nx1_q) * PD_W'(dx1_q);
    pdy2_q <= PD_W'(ny1_q) * PD_W'(dy1_q);
    pdz2_q <= PD_W'(nz1_q) * PD_W'(dz1_q);
    pax2_q <= PA_W'(nx1_q) * PA_W'(ax1_q);
    pay2_q <= PA_W'(ny1_q) * PA_W'(ay1_q);
    paz2_q <= PA_W'(nz1_q) * PA_W'(az1_q);
    nn2_q  <= NN_W'($unsigned(sx1_q)) + NN_W'($unsigned(sy1_q)) + NN_W'($unsigned(sz1_q));
  end

  // ---- stage 3: den, n.A, d * (n.n)
  logic                      v3_q;
  logic signed [COORD_W-1:0] ax3_q, ay3_q, az3_q;
  logic signed [DIR_W-1:0]   dx3_q, dy3_q, dz3_q;
  logic [THR_W-1:0]          thr3_q;
  logic                      any3_q, unb3_q;
  logic signed [DEN_W-1:0]   den3_q;
  logic signed [NA_W-1:0]    na3_q;
  logic signed [DNN_W-1:0]   dnn3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ax3_q  <= ax2_q;
    ay3_q  <= ay2_q;
    az3_q  <= az2_q;
    dx3_q  <= dx2_q;
    dy3_q  <= dy2_q;
    dz3_q  <= dz2_q;
    thr3_q <= thr2_q;
    any3_q <= any2_q;
    unb3_q <= unb2_q;
    den3_q <= -(DEN_W'(pdx2_q) + DEN_W'(pdy2_q) + DEN_W'(pdz2_q));
    na3_q  <= NA_W'(pax2_q) + NA_W'(pay2_q) + NA_W'(paz2_q);
    dnn3_q <= DNN_W'(d2_q) * DNN_W'($signed({1'b0, nn2_q}));
  end

  // ---- stage 4: numerator with floored offset term
  logic                      v4_q;
  logic signed [COORD_W-1:0] ax4_q, ay4_q, az4_q;
  logic signed [DIR_W-1:0]   dx4_q, dy4_q, dz4_q;
  logic [THR_W-1:0]          thr4_q;
  logic                      any4_q, unb4_q;
  logic signed [DEN_W-1:0]   den4_q;
  logic signed [NUM_W-1:0]   num4_q;
  logic signed [DNN_W-1:0]   dnn_sh;

  assign dnn_sh = dnn3_q >>> NORMAL_FRAC_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ax4_q  <= ax3_q;
    ay4_q  <= ay3_q;
    az4_q  <= az3_q;
    dx4_q  <= dx3_q;
    dy4_q  <= dy3_q;
    dz4_q  <= dz3_q;
    thr4_q <= thr3_q;
    any4_q <= any3_q;
    unb4_q <= unb3_q;
    den4_q <= den3_q;
    num4_q <= NUM_W'(na3_q) - NUM_W'(dnn_sh);
  end

  // ---- stage 5: magnitudes and accept/reject decision
  logic [NUM_W-1:0] an;
  logic [DEN_W-1:0] ad, thr_sc;
  logic             den_neg, num_neg, miss;

  always_comb begin
    den_neg = den4_q[DEN_W-1];
    num_neg = num4_q[NUM_W-1];
    an      = num_neg ? NUM_W'(-num4_q) : NUM_W'(num4_q);
    ad      = den_neg ? DEN_W'(-den4_q) : DEN_W'(den4_q);
    thr_sc  = DEN_W'(thr4_q) << NORMAL_FRAC_BITS;
    miss    = 1'b0;
    if (ad == '0 || ad < thr_sc) begin
      miss = 1'b1;
    end
    if (!any4_q && den_neg) begin
      miss = 1'b1;
    end
    if (!unb4_q && num4_q != '0) begin
      if (num_neg != den_neg || an > NUM_W'(ad)) begin
        miss = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    an_o        <= an;
    ad_o        <= ad;
    side_o.ax   <= ax4_q;
    side_o.ay   <= ay4_q;
    side_o.az   <= az4_q;
    side_o.dx   <= dx4_q;
    side_o.dy   <= dy4_q;
    side_o.dz   <= dz4_q;
    side_o.miss <= miss;
    side_o.neg  <= num_neg ^ den_neg;
  end

endmodule

// ===== rtl/lpi_div.sv =====
module lpi_div import lpi_pkg::*; #(
  parameter int COORD_FRAC_BITS = 16,
  parameter int NUM_W           = 51
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] an_i,
  input  logic [DEN_W-1:0] ad_i,
  input  side_t            side_i,
  output logic             valid_o,
  output logic [QUO_W-1:0] q_o,
  output logic             ov_o,
  output side_t            side_o
);

  localparam int INT_BITS = QUO_W - COORD_FRAC_BITS;
  localparam int CMP_W    = NUM_W + QUO_W;
  localparam int NSTAGE   = QUO_W + 1;

  logic             v_q    [NSTAGE];
  logic [NUM_W-1:0] an_q   [NSTAGE];
  logic [DEN_W-1:0] ad_q   [NSTAGE];
  logic [DEN_W-1:0] p_q    [NSTAGE];
  logic [QUO_W-1:0] q_q    [NSTAGE];
  logic             ov_q   [NSTAGE];
  side_t            side_q [NSTAGE];

  // Entry stage: integer-part overflow check and first partial remainder
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    an_q[0]   <= an_i;
    ad_q[0]   <= ad_i;
    p_q[0]    <= DEN_W'(an_i >> INT_BITS);
    q_q[0]    <= '0;
    ov_q[0]   <= CMP_W'(an_i) >= (CMP_W'(ad_i) << INT_BITS);
    side_q[0] <= side_i;
  end

  // One restoring step per stage, quotient bit QUO_W-i in stage i
  for (genvar i = 1; i < NSTAGE; i++) begin : g_step
    localparam int K = QUO_W - i;
    logic             nbit, ge;
    logic [DEN_W:0]   t;

    if (K >= COORD_FRAC_BITS) begin : g_bit
      assign nbit = an_q[i-1][K-COORD_FRAC_BITS];
    end else begin : g_zero
      assign nbit = 1'b0;
    end

    assign t  = {p_q[i-1], nbit};
    assign ge = t >= {1'b0, ad_q[i-1]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else begin
        v_q[i] <= v_q[i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      an_q[i]   <= an_q[i-1];
      ad_q[i]   <= ad_q[i-1];
      p_q[i]    <= ge ? DEN_W'(t - {1'b0, ad_q[i-1]}) : DEN_W'(t);
      q_q[i]    <= {q_q[i-1][QUO_W-2:0], ge};
      ov_q[i]   <= ov_q[i-1];
      side_q[i] <= side_q[i-1];
    end
  end

  assign valid_o = v_q[NSTAGE-1];
  assign q_o     = q_q[NSTAGE-1];
  assign ov_o    = ov_q[NSTAGE-1];
  assign side_o  = side_q[NSTAGE-1];

endmodule

// ===== rtl/lpi_back.sv =====
module lpi_back import lpi_pkg::*; #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [QUO_W-1:0]          q_i,
  input  logic                      ov_i,
  input  side_t                     side_i,
  output logic                      valid_o,
  output logic                      hit_o,
  output logic signed [COORD_W-1:0] cross_x_o,
  output logic signed [COORD_W-1:0] cross_y_o,
  output logic signed [COORD_W-1:0] cross_z_o,
  output logic signed [COORD_W-1:0] fraction_o
);

  localparam int MAG_W  = COORD_W;
  localparam int PROD_W = 2 * MAG_W;
  localparam int T_W    = PROD_W + 1;
  localparam int S_W    = T_W + 1;
  localparam logic [QUO_W-1:0] POS_MAX = {1'b0, {(QUO_W-1){1'b1}}};
  localparam logic [QUO_W-1:0] NEG_MAX = {1'b1, {(QUO_W-1){1'b0}}};

  // ---- b1: saturate quotient, split direction into sign and magnitude
  logic [QUO_W-1:0] umag;
  always_comb begin
    if (side_i.neg) begin
      umag = (ov_i || q_i > NEG_MAX) ? NEG_MAX : q_i;
    end else begin
      umag = (ov_i || q_i > POS_MAX) ? POS_MAX : q_i;
    end
  end

  logic                      v1_q, neg1_q, miss1_q;
  logic [MAG_W-1:0]          um1_q, mx1_q, my1_q, mz1_q;
  logic                      sx1_q, sy1_q, sz1_q;
  logic signed [COORD_W-1:0] u1_q, ax1_q, ay1_q, az1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    neg1_q  <= side_i.neg;
    miss1_q <= side_i.miss;
    um1_q   <= umag;
    u1_q    <= side_i.neg ? $signed(-umag) : $signed(umag);
    sx1_q   <= side_i.dx[DIR_W-1];
    sy1_q   <= side_i.dy[DIR_W-1];
    sz1_q   <= side_i.dz[DIR_W-1];
    mx1_q   <= MAG_W'(side_i.dx[DIR_W-1] ? -side_i.dx : side_i.dx);
    my1_q   <= MAG_W'(side_i.dy[DIR_W-1] ? -side_i.dy : side_i.dy);
    mz1_q   <= MAG_W'(side_i.dz[DIR_W-1] ? -side_i.dz : side_i.dz);
    ax1_q   <= side_i.ax;
    ay1_q   <= side_i.ay;
    az1_q   <= side_i.az;
  end

  // ---- b2: u * dir magnitudes
  logic                      v2_q, miss2_q;
  logic [PROD_W-1:0]         px2_q, py2_q, pz2_q;
  logic                      sx2_q, sy2_q, sz2_q;
  logic signed [COORD_W-1:0] u2_q, ax2_q, ay2_q, az2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    miss2_q <= miss1_q;
    px2_q   <= PROD_W'(um1_q) * PROD_W'(mx1_q);
    py2_q   <= PROD_W'(um1_q) * PROD_W'(my1_q);
    pz2_q   <= PROD_W'(um1_q) * PROD_W'(mz1_q);
    sx2_q   <= neg1_q ^ sx1_q;
    sy2_q   <= neg1_q ^ sy1_q;
    sz2_q   <= neg1_q ^ sz1_q;
    u2_q    <= u1_q;
    ax2_q   <= ax1_q;
    ay2_q   <= ay1_q;
    az2_q   <= az1_q;
  end

  // ---- b3: scale, add start point, saturate
  function automatic logic signed [COORD_W-1:0] step_sat(
    input logic signed [COORD_W-1:0] a,
    input logic [PROD_W-1:0]         p,
    input logic                      sgn
  );
    logic signed [T_W-1:0] t;
    logic signed [S_W-1:0] s;
    logic signed [S_W-1:0] hi, lo;
    t  = $signed({1'b0, p >> COORD_FRAC_BITS});
    if (sgn) begin
      t = -t;
    end
    s  = S_W'(a) + S_W'(t);
    hi = S_W'({1'b0, {(COORD_W-1){1'b1}}});
    lo = -hi - S_W'(1);
    if (s > hi) begin
      return hi[COORD_W-1:0];
    end else if (s < lo) begin
      return lo[COORD_W-1:0];
    end
    return s[COORD_W-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (miss2_q) begin
      hit_o      <= 1'b0;
      cross_x_o  <= '0;
      cross_y_o  <= '0;
      cross_z_o  <= '0;
      fraction_o <= '0;
    end else begin
      hit_o      <= 1'b1;
      cross_x_o  <= step_sat(ax2_q, px2_q, sx2_q);
      cross_y_o  <= step_sat(ay2_q, py2_q, sy2_q);
      cross_z_o  <= step_sat(az2_q, pz2_q, sz2_q);
      fraction_o <= u2_q;
    end
  end

endmodule

// ===== rtl/line_plane_intersection_top.sv =====
// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+--------------------------------------
// segment   | in        | start, busy        | start_x/y/z_i, end_x/y/z_i, any_direction_i,
//           |           |                    | unbounded_line_i
// result    | out       | done_o (strobe)    | hit_o, cross_x/y/z_o, fraction_o
// config    | in        | cfg_we_i           | cfg_idx_i, cfg_data_i
//
// One item enters per clock; each item passes through 5 front-end stages, 33 divider
// stages and 3 back-end stages. The 32 restoring steps of u = num/den, one quotient
// bit per stage, set the depth. busy stays low: the pipeline never stalls, so the
// receiver must take every result in the cycle it is shown; the block itself does
// not enforce this. Reset clears the valid bits and loads the register defaults;
// no data register is cleared.
module line_plane_intersection_top import lpi_pkg::*; #(
  parameter int COORD_FRAC_BITS  = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // segment in
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] start_x_i,
  input  logic signed [COORD_W-1:0] start_y_i,
  input  logic signed [COORD_W-1:0] start_z_i,
  input  logic signed [COORD_W-1:0] end_x_i,
  input  logic signed [COORD_W-1:0] end_y_i,
  input  logic signed [COORD_W-1:0] end_z_i,
  input  logic                      any_direction_i,
  input  logic                      unbounded_line_i,
  // result out
  output logic                      done_o,
  output logic                      hit_o,
  output logic signed [COORD_W-1:0] cross_x_o,
  output logic signed [COORD_W-1:0] cross_y_o,
  output logic signed [COORD_W-1:0] cross_z_o,
  output logic signed [COORD_W-1:0] fraction_o,
  // config write
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [COORD_W-1:0]        cfg_data_i
);

  // Numerator width: d*(n.n) floored by the normal fraction, or n.A,
  // whichever is wider, plus a sign bit.
  localparam int NUM_BODY = (64 - NORMAL_FRAC_BITS) > 49 ? (64 - NORMAL_FRAC_BITS) : 49;
  localparam int NUM_W    = NUM_BODY + 1;

  localparam logic [NORM_W-1:0] NY_RESET  = NORM_W'(1) << NORMAL_FRAC_BITS;
  localparam logic [THR_W-1:0]  THR_RESET = THR_W'(66);

  // Plane registers; the user must write them only while the pipeline is empty (not enforced here)
  logic signed [NORM_W-1:0]  nx_q, ny_q, nz_q;
  logic signed [COORD_W-1:0] offset_q;
  logic [THR_W-1:0]          thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nx_q     <= '0;
      ny_q     <= NY_RESET;
      nz_q     <= '0;
      offset_q <= '0;
      thr_q    <= THR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_NORMAL_X:  nx_q     <= cfg_data_i[NORM_W-1:0];
        REG_NORMAL_Y:  ny_q     <= cfg_data_i[NORM_W-1:0];
        REG_NORMAL_Z:  nz_q     <= cfg_data_i[NORM_W-1:0];
        REG_OFFSET:    offset_q <= cfg_data_i;
        REG_THRESHOLD: thr_q    <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic             take;
  logic             f_valid, d_valid;
  logic [NUM_W-1:0] f_an;
  logic [DEN_W-1:0] f_ad;
  side_t            f_side, d_side;
  logic [QUO_W-1:0] d_q;
  logic             d_ov;

  // accept an item whenever start is raised
  assign take = start & ~busy;

  // Front end: dot products, numerator/denominator, hit/miss decision
  lpi_front #(
    .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS),
    .NUM_W            (NUM_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (take),
    .ax_i        (start_x_i),
    .ay_i        (start_y_i),
    .az_i        (start_z_i),
    .bx_i        (end_x_i),
    .by_i        (end_y_i),
    .bz_i        (end_z_i),
    .any_dir_i   (any_direction_i),
    .unbounded_i (unbounded_line_i),
    .nx_i        (nx_q),
    .ny_i        (ny_q),
    .nz_i        (nz_q),
    .offset_i    (offset_q),
    .thr_i       (thr_q),
    .valid_o     (f_valid),
    .an_o        (f_an),
    .ad_o        (f_ad),
    .side_o      (f_side)
  );

  // Pipelined divider: |num| * 2^CF / |den|, one bit per stage
  lpi_div #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .NUM_W           (NUM_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .an_i    (f_an),
    .ad_i    (f_ad),
    .side_i  (f_side),
    .valid_o (d_valid),
    .q_o     (d_q),
    .ov_o    (d_ov),
    .side_o  (d_side)
  );

  // Back end: saturate u, advance the start point along dir
  lpi_back #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (d_valid),
    .q_i        (d_q),
    .ov_i       (d_ov),
    .side_i     (d_side),
    .valid_o    (done_o),
    .hit_o      (hit_o),
    .cross_x_o  (cross_x_o),
    .cross_y_o  (cross_y_o),
    .cross_z_o  (cross_z_o),
    .fraction_o (fraction_o)
  );

endmodule
